/* rtl/fsmr_pkg.sv */
// Shared types and constants for the source-matching queue.
// No dependencies; imported by fsmr_cell, fsmr_chain and the top level.
package fsmr_pkg;

  // Field widths on the stream ports
  localparam int KIND_W      = 2;
  localparam int SRC_W       = 16;
  localparam int PAY_W       = 32;
  localparam int POS_W       = 4;
  localparam int CNT_OUT_W   = 5;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = 1;

  // Operation codes carried on in_tuser
  localparam logic [KIND_W-1:0] KIND_ENQ      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEQ_SRC  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FIND_SRC = 2'd3;

  // Per-cycle commands from the controller to the cell chain
  typedef struct packed {
    logic shift;  // non-last cells take their upper neighbor's entry
    logic write;  // the addressed cell loads the write bus
  } fsmr_ctrl_t;

endpackage

/* rtl/fsmr_cell.sv */
// One queue slot: holds a source rank and a payload.
// Depends on fsmr_pkg for the chain command struct.
module fsmr_cell #(
  parameter int SOURCE_BITS  = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                      clk,
  input  fsmr_pkg::fsmr_ctrl_t      ctrl,
  input  logic                      sel,
  input  logic [SOURCE_BITS-1:0]    wr_src,
  input  logic [PAYLOAD_BITS-1:0]   wr_pay,
  input  logic [SOURCE_BITS-1:0]    nb_src,
  input  logic [PAYLOAD_BITS-1:0]   nb_pay,
  output logic [SOURCE_BITS-1:0]    src,
  output logic [PAYLOAD_BITS-1:0]   pay
);
  import fsmr_pkg::*;

  logic [SOURCE_BITS-1:0]  src_r, src_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;

  // Write bus wins over the shift so the tail slot can take the rotated head.
  always_comb begin
    src_nxt = src_r;
    pay_nxt = pay_r;
    if (ctrl.write && sel) begin
      src_nxt = wr_src;
      pay_nxt = wr_pay;
    end else if (ctrl.shift) begin
      src_nxt = nb_src;
      pay_nxt = nb_pay;
    end
  end

  always_ff @(posedge clk) begin
    src_r <= src_nxt;
    pay_r <= pay_nxt;
  end

  assign src = src_r;
  assign pay = pay_r;

endmodule

/* rtl/fsmr_chain.sv */
// Row of DEPTH queue cells, slot 0 at the head, shifting toward the head.
// Depends on fsmr_pkg and fsmr_cell.
module fsmr_chain #(
  parameter int DEPTH        = 16,
  parameter int SOURCE_BITS  = 16,
  parameter int PAYLOAD_BITS = 32,
  parameter int IDX_W        = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  fsmr_pkg::fsmr_ctrl_t      ctrl,
  input  logic [IDX_W-1:0]          wr_idx,
  input  logic [SOURCE_BITS-1:0]    wr_src,
  input  logic [PAYLOAD_BITS-1:0]   wr_pay,
  output logic [SOURCE_BITS-1:0]    head_src,
  output logic [PAYLOAD_BITS-1:0]   head_pay
);
  import fsmr_pkg::*;

  logic [SOURCE_BITS-1:0]  src_q  [DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_q  [DEPTH];
  logic [SOURCE_BITS-1:0]  nb_src [DEPTH];
  logic [PAYLOAD_BITS-1:0] nb_pay [DEPTH];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      // The last slot has no upper neighbor; it recirculates its own value.
      if (i == DEPTH - 1) begin : g_last
        assign nb_src[i] = src_q[i];
        assign nb_pay[i] = pay_q[i];
      end else begin : g_mid
        assign nb_src[i] = src_q[i+1];
        assign nb_pay[i] = pay_q[i+1];
      end

      fsmr_cell #(
        .SOURCE_BITS  (SOURCE_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
        .clk    (clk),
        .ctrl   (ctrl),
        .sel    (wr_idx == IDX_W'(i)),
        .wr_src (wr_src),
        .wr_pay (wr_pay),
        .nb_src (nb_src[i]),
        .nb_pay (nb_pay[i]),
        .src    (src_q[i]),
        .pay    (pay_q[i])
      );
    end
  endgenerate

  assign head_src = src_q[0];
  assign head_pay = pay_q[0];

endmodule

/* rtl/fifo_with_source_match_removal.sv */
// Top level of the bounded queue with removal by source rank.
// Depends on fsmr_pkg, fsmr_chain (and through it fsmr_cell).
//
//  Channel | Direction | Handshake          | Contents
//  --------+-----------+--------------------+--------------------------------------------
//  in_     | slave     | in_tvalid/tready   | tuser: kind; tdata: source_rank, payload
//  out_    | master    | out_tvalid/tready  | tuser: ok; tdata: source, payload, pos, count
//
// Enqueue and dequeue of the head pass from input transfer through the execute
// and done states to the output register. Dequeue by source and find stay in the
// execute state through all N entries held: the cell ring rotates one entry per
// cycle past the head comparator, so a full pass restores the order (minus a
// removed entry). Reset clears the entry count, the sequencer and the output
// valid; cell contents stay as they are. One item is in work at a time; the next
// input transfer is taken while a finished result still waits in the output
// register, and a second finished result holds the input until that one drains.
module fifo_with_source_match_removal #(
  parameter int DEPTH        = 16,
  parameter int SOURCE_BITS  = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [fsmr_pkg::IN_TDATA_W-1:0]     in_tdata,   // [15:0] source_rank, [47:16] payload
  input  logic [fsmr_pkg::KIND_W-1:0]         in_tuser,   // [1:0] kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [fsmr_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [15:0] out_source,
                                                          // [47:16] out_payload,
                                                          // [51:48] position,
                                                          // [56:52] entry_count, rest 0
  output logic [fsmr_pkg::OUT_TUSER_W-1:0]    out_tuser   // [0] ok
);
  import fsmr_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Operation registers
  logic [1:0]               state_r, state_nxt;
  logic [KIND_W-1:0]        kind_r, kind_nxt;
  logic [SOURCE_BITS-1:0]   key_r, key_nxt;
  logic [PAYLOAD_BITS-1:0]  pay_r, pay_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         steps_r, steps_nxt;
  logic [IDX_W-1:0]         pos_r, pos_nxt;
  logic                     found_r, found_nxt;

  // Finished result, waiting for the output register
  logic                     res_ok_r, res_ok_nxt;
  logic [SOURCE_BITS-1:0]   res_src_r, res_src_nxt;
  logic [PAYLOAD_BITS-1:0]  res_pay_r, res_pay_nxt;
  logic [IDX_W-1:0]         res_pos_r, res_pos_nxt;

  // Output register
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]   out_data_r, out_data_nxt;
  logic                     out_ok_r, out_ok_nxt;

  // Chain interface
  fsmr_ctrl_t               ctrl;
  logic [IDX_W-1:0]         wr_idx;
  logic [SOURCE_BITS-1:0]   wr_src;
  logic [PAYLOAD_BITS-1:0]  wr_pay;
  logic [SOURCE_BITS-1:0]   head_src;
  logic [PAYLOAD_BITS-1:0]  head_pay;

  // Field resizing between port widths and parameter widths
  logic [SOURCE_BITS+SRC_W-1:0]   in_src_ext;
  logic [PAYLOAD_BITS+PAY_W-1:0]  in_pay_ext;
  logic [SRC_W+SOURCE_BITS-1:0]   o_src_ext;
  logic [PAY_W+PAYLOAD_BITS-1:0]  o_pay_ext;
  logic [POS_W+IDX_W-1:0]         o_pos_ext;
  logic [CNT_OUT_W+CNT_W-1:0]     o_cnt_ext;

  logic in_xfer;
  logic out_free;
  logic head_match;

  assign in_src_ext = {{SOURCE_BITS{1'b0}}, in_tdata[SRC_W-1:0]};
  assign in_pay_ext = {{PAYLOAD_BITS{1'b0}}, in_tdata[SRC_W+PAY_W-1:SRC_W]};
  assign o_src_ext  = {{SRC_W{1'b0}}, res_src_r};
  assign o_pay_ext  = {{PAY_W{1'b0}}, res_pay_r};
  assign o_pos_ext  = {{POS_W{1'b0}}, res_pos_r};
  assign o_cnt_ext  = {{CNT_OUT_W{1'b0}}, count_r};

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign head_match = (head_src == key_r) && !found_r;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    pay_nxt       = pay_r;
    count_nxt     = count_r;
    steps_nxt     = steps_r;
    pos_nxt       = pos_r;
    found_nxt     = found_r;
    res_ok_nxt    = res_ok_r;
    res_src_nxt   = res_src_r;
    res_pay_nxt   = res_pay_r;
    res_pos_nxt   = res_pos_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_ok_nxt    = out_ok_r;
    ctrl          = '0;
    wr_idx        = count_r[IDX_W-1:0];
    wr_src        = key_r;
    wr_pay        = pay_r;

    // Drain the output register on transfer
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          kind_nxt    = in_tuser;
          key_nxt     = in_src_ext[SOURCE_BITS-1:0];
          pay_nxt     = in_pay_ext[PAYLOAD_BITS-1:0];
          steps_nxt   = count_r;
          pos_nxt     = '0;
          found_nxt   = 1'b0;
          res_ok_nxt  = 1'b0;
          res_src_nxt = '0;
          res_pay_nxt = '0;
          res_pos_nxt = '0;
          state_nxt   = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (kind_r)
          KIND_ENQ: begin
            // Append at the first free slot
            if (count_r < CNT_W'(DEPTH)) begin
              ctrl.write = 1'b1;
              count_nxt  = count_r + 1'b1;
              res_ok_nxt = 1'b1;
            end
            state_nxt = ST_DONE;
          end
          KIND_DEQ: begin
            // Take the head and advance the row
            if (count_r != '0) begin
              ctrl.shift  = 1'b1;
              count_nxt   = count_r - 1'b1;
              res_ok_nxt  = 1'b1;
              res_src_nxt = head_src;
              res_pay_nxt = head_pay;
            end
            state_nxt = ST_DONE;
          end
          default: begin
            // Rotate: the head drops into the tail slot, or is dropped on a
            // first match when removing by source.
            if (steps_r == '0) begin
              res_ok_nxt = found_r;
              state_nxt  = ST_DONE;
            end else begin
              ctrl.shift = 1'b1;
              steps_nxt  = steps_r - 1'b1;
              pos_nxt    = pos_r + 1'b1;
              wr_idx     = IDX_W'(count_r - 1'b1);
              wr_src     = head_src;
              wr_pay     = head_pay;
              if (head_match) begin
                found_nxt = 1'b1;
                if (kind_r == KIND_DEQ_SRC) begin
                  count_nxt   = count_r - 1'b1;
                  res_src_nxt = head_src;
                  res_pay_nxt = head_pay;
                end else begin
                  ctrl.write  = 1'b1;
                  res_pos_nxt = pos_r;
                end
              end else begin
                ctrl.write = 1'b1;
              end
            end
          end
        endcase
      end

      ST_DONE: begin
        // Hold the result until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_data_nxt  = {{(OUT_TDATA_W-SRC_W-PAY_W-POS_W-CNT_OUT_W){1'b0}},
                           o_cnt_ext[CNT_OUT_W-1:0], o_pos_ext[POS_W-1:0],
                           o_pay_ext[PAY_W-1:0], o_src_ext[SRC_W-1:0]};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    key_r      <= key_nxt;
    pay_r      <= pay_nxt;
    steps_r    <= steps_nxt;
    pos_r      <= pos_nxt;
    found_r    <= found_nxt;
    res_ok_r   <= res_ok_nxt;
    res_src_r  <= res_src_nxt;
    res_pay_r  <= res_pay_nxt;
    res_pos_r  <= res_pos_nxt;
    out_data_r <= out_data_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  fsmr_chain #(
    .DEPTH        (DEPTH),
    .SOURCE_BITS  (SOURCE_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_chain (
    .clk      (clk),
    .ctrl     (ctrl),
    .wr_idx   (wr_idx),
    .wr_src   (wr_src),
    .wr_pay   (wr_pay),
    .head_src (head_src),
    .head_pay (head_pay)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ok_r;

endmodule

/* tb/sv/tb_fifo_with_source_match_removal.sv */
// Self-checking bench for fifo_with_source_match_removal: random and directed queue operations,
// each result checked field by field against a shadow queue kept in the bench.
// Depends on fsmr_pkg and the top level fifo_with_source_match_removal.
`timescale 1ns / 1ps

module tb_fifo_with_source_match_removal;
  import fsmr_pkg::*;

  localparam int QDEPTH      = 16;
  localparam int N_RANDOM    = 850;
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_CYCLES = 200;    // long receiver hold-off
  localparam int HOLD_AFTER  = 300;    // input transfers before the hold-off

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [SRC_W-1:0]  rank;
    logic [PAY_W-1:0]  pay;
  } queue_op_t;

  typedef struct {
    logic               ok;
    logic [SRC_W-1:0]   rank;
    logic [PAY_W-1:0]   pay;
    logic [POS_W-1:0]   pos;
    logic [CNT_OUT_W-1:0] cnt;
    logic [6:0]         pad;
  } queue_reply_t;

  // Clock, reset and DUT ports; every input starts at a known value
  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata   = '0;   // [15:0] source_rank, [47:16] payload
  logic [KIND_W-1:0]       in_tuser   = '0;   // [1:0] kind
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;         // [15:0] source, [47:16] payload,
                                              // [51:48] position, [56:52] count
  logic [OUT_TUSER_W-1:0]  out_tuser;         // [0] ok

  // Shadow queue: slot 0 is the head
  logic [SRC_W-1:0] shadow_rank [QDEPTH];
  logic [PAY_W-1:0] shadow_pay  [QDEPTH];
  int               shadow_n = 0;

  queue_op_t    op_backlog [$];   // items still to be sent
  queue_reply_t owed_replies [$]; // results predicted but not yet seen
  queue_op_t    cur_op;
  bit           cur_loaded   = 1'b0;
  int           send_gap     = 0;
  int           rx_wait      = 0;
  int           tx_calm      = 0;
  int           rx_calm      = 0;
  bit           in_took      = 1'b0;
  bit           out_took     = 1'b0;
  bit           rx_hold      = 1'b0;
  int           ops_accepted = 0;
  int           mismatches   = 0;
  logic [SRC_W-1:0] rank_pool [8];

  fifo_with_source_match_removal #(
    .DEPTH        (QDEPTH),
    .SOURCE_BITS  (SRC_W),
    .PAYLOAD_BITS (PAY_W)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle length for one item drawn from a uniform range, with occasional stretches of none
  function automatic int pick_gap(ref int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) calm_left = $urandom_range(15, 40);
    return $urandom_range(0, 8);
  endfunction

  // Apply one operation to the shadow queue and return the result it must give
  function automatic queue_reply_t apply_queue_op(queue_op_t op);
    queue_reply_t r;
    int hit;
    r = '{default: '0};
    hit = -1;
    case (op.kind)
      KIND_ENQ: begin
        if (shadow_n < QDEPTH) begin
          shadow_rank[shadow_n] = op.rank;
          shadow_pay[shadow_n]  = op.pay;
          shadow_n++;
          r.ok = 1'b1;
        end
      end
      KIND_DEQ: begin
        if (shadow_n > 0) hit = 0;
      end
      default: begin
        // oldest match wins
        for (int i = shadow_n - 1; i >= 0; i--)
          if (shadow_rank[i] == op.rank) hit = i;
      end
    endcase
    if (hit >= 0) begin
      r.ok = 1'b1;
      if (op.kind == KIND_FIND_SRC) begin
        r.pos = POS_W'(hit);
      end else begin
        r.rank = shadow_rank[hit];
        r.pay  = shadow_pay[hit];
        // close the gap behind the removed entry
        for (int i = hit; i < shadow_n - 1; i++) begin
          shadow_rank[i] = shadow_rank[i + 1];
          shadow_pay[i]  = shadow_pay[i + 1];
        end
        shadow_n--;
      end
    end
    r.cnt = CNT_OUT_W'(shadow_n);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Sample both channels at the rising edge. Check the output transfer first,
  // then predict the result of the input transfer taken at the same edge.
  always @(posedge clk) begin
    queue_reply_t got;
    queue_reply_t want;
    queue_op_t    seen;
    in_took  = 1'b0;
    out_took = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        out_took = 1'b1;
        got.ok   = out_tuser[0];
        got.rank = out_tdata[15:0];
        got.pay  = out_tdata[47:16];
        got.pos  = out_tdata[51:48];
        got.cnt  = out_tdata[56:52];
        got.pad  = out_tdata[63:57];
        if (owed_replies.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got %0h/%0h",
                   $time, out_tuser, out_tdata);
          mismatches++;
        end else begin
          want = owed_replies.pop_front();
          check_field("ok", 32'(want.ok), 32'(got.ok));
          check_field("out_source", 32'(want.rank), 32'(got.rank));
          check_field("out_payload", want.pay, got.pay);
          check_field("position", 32'(want.pos), 32'(got.pos));
          check_field("entry_count", 32'(want.cnt), 32'(got.cnt));
          check_field("padding", 32'(want.pad), 32'(got.pad));
        end
      end
      if (in_tvalid && in_tready) begin
        in_took = 1'b1;
        ops_accepted++;
        seen.kind = in_tuser;
        seen.rank = in_tdata[15:0];
        seen.pay  = in_tdata[47:16];
        owed_replies.push_back(apply_queue_op(seen));
      end
    end
  end

  // Sender: drop the item just transferred, load the next one with its own
  // idle gap, then hold tvalid until the block takes it. One assignment per edge.
  always @(negedge clk) begin
    if (in_took) cur_loaded = 1'b0;
    if (rst_n && !cur_loaded && op_backlog.size() > 0) begin
      cur_op     = op_backlog.pop_front();
      cur_loaded = 1'b1;
      send_gap   = pick_gap(tx_calm);
    end
    if (cur_loaded && send_gap > 0) begin
      send_gap--;
      in_tvalid <= 1'b0;
    end else begin
      in_tvalid <= cur_loaded;
    end
    if (cur_loaded) begin
      in_tdata <= {cur_op.pay, cur_op.rank};
      in_tuser <= cur_op.kind;
    end
  end

  // Receiver: draw a fresh stall after each result; the long hold-off overrides
  always @(negedge clk) begin
    if (out_took) rx_wait = pick_gap(rx_calm);
    if (rx_wait > 0) begin
      rx_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && !rx_hold;
    end
  end

  // Long hold-off on the result side while the sender keeps offering items,
  // so the output register fills and the input stalls
  initial begin
    while (ops_accepted < HOLD_AFTER) @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  task automatic queue_op(logic [KIND_W-1:0] kind, logic [SRC_W-1:0] rank,
                          logic [PAY_W-1:0] pay);
    queue_op_t op;
    op.kind = kind;
    op.rank = rank;
    op.pay  = pay;
    op_backlog.push_back(op);
  endtask

  // Ranks mostly from a small pool so that matches are common
  function automatic logic [SRC_W-1:0] pick_rank();
    if ($urandom_range(0, 4) == 0) return SRC_W'($urandom);
    return rank_pool[$urandom_range(0, 7)];
  endfunction

  // Stimulus, end-of-run drain and the final verdict
  initial begin
    int made;
    int mode;
    int run_len;
    int roll;
    logic [KIND_W-1:0] kind;

    rank_pool[0] = '0;
    rank_pool[1] = '1;
    for (int i = 2; i < 8; i++) rank_pool[i] = SRC_W'($urandom);

    // Directed: operations on an empty queue
    queue_op(KIND_DEQ, 16'h0000, 32'h0);
    queue_op(KIND_DEQ_SRC, 16'h0000, 32'hFFFF_FFFF);
    queue_op(KIND_FIND_SRC, 16'hFFFF, 32'h0);
    // Fill to the brim with extreme values; a duplicate rank sits at slot 9
    queue_op(KIND_ENQ, 16'h0000, 32'h0000_0000);
    queue_op(KIND_ENQ, 16'hFFFF, 32'hFFFF_FFFF);
    queue_op(KIND_ENQ, 16'hAAAA, 32'h5555_5555);
    queue_op(KIND_ENQ, 16'h5555, 32'hAAAA_AAAA);
    for (int i = 4; i < QDEPTH; i++)
      queue_op(KIND_ENQ, (i == 9) ? 16'hFFFF : 16'(16'h0101 * i), $urandom);
    // Enqueue when full, find and remove a duplicate rank, find at the tail, look for an absent rank, dequeue the head
    queue_op(KIND_ENQ, 16'h1111, 32'h1234_5678);
    queue_op(KIND_FIND_SRC, 16'hFFFF, 32'h0);
    queue_op(KIND_FIND_SRC, 16'h0F0F, 32'h0);
    queue_op(KIND_DEQ_SRC, 16'hFFFF, 32'h0);
    queue_op(KIND_FIND_SRC, 16'h1234, 32'h0);
    queue_op(KIND_DEQ_SRC, 16'h1234, 32'h0);
    queue_op(KIND_DEQ, 16'h0000, 32'h0);
    queue_op(KIND_ENQ, 16'h8001, 32'h8000_0001);

    // Random: runs that lean toward filling, draining or an even mix
    made = 0;
    while (made < N_RANDOM) begin
      mode    = $urandom_range(0, 2);
      run_len = $urandom_range(10, 50);
      for (int j = 0; j < run_len && made < N_RANDOM; j++) begin
        roll = $urandom_range(0, 9);
        case (mode)
          0:       kind = (roll < 6) ? KIND_ENQ : (roll == 6) ? KIND_DEQ :
                          (roll == 7) ? KIND_DEQ_SRC : KIND_FIND_SRC;
          1:       kind = (roll < 1) ? KIND_ENQ : (roll < 5) ? KIND_DEQ :
                          (roll < 8) ? KIND_DEQ_SRC : KIND_FIND_SRC;
          default: kind = KIND_W'($urandom_range(0, 3));
        endcase
        queue_op(kind, pick_rank(), $urandom);
        made++;
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Hold until every item is sent and every result has come back
    while (op_backlog.size() != 0 || cur_loaded || owed_replies.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && owed_replies.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
